// ===== rtl/core/lockord_pkg.sv =====
`default_nettype none

package lockord_pkg;

   // fixed field widths of the request and response
   localparam int unsigned LEVEL_FIELD_BITS = 8;
   localparam int unsigned COUNT_FIELD_BITS = 5;

   // request operation codes
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;

   // response status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_VIOLATION = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_STOPPED   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]                  operation;
      logic [LEVEL_FIELD_BITS-1:0] level;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [LEVEL_FIELD_BITS-1:0] conflict_level;
      logic [COUNT_FIELD_BITS-1:0] count_held;
      logic                        last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/lockord_ram.sv =====
`default_nettype none

module lockord_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/lock_order_checker.sv =====
`default_nettype none

// Lock order checker. Holds up to MAX_HELD lock levels in a single-port-read
// RAM and serves one request at a time. Push, stopped, empty-table and unused
// requests answer in the accept cycle. A check walks the table one entry per
// cycle through the registered RAM read port; every violating entry gives one
// response, the last response carries last. A pop walks from the top down, one
// entry per cycle, and on a match ends with a write that moves the top entry
// into the freed slot. Response backpressure stalls the walk. With csr fatal
// mode set, the first violation is reported alone and the block answers every
// later request with a stopped status until reset.
module lock_order_checker #(
   parameter int unsigned MAX_HELD = 16,
   parameter int unsigned LEVEL_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lockord_pkg::req_type req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output lockord_pkg::rsp_type     rsp_payload,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data
);

   import lockord_pkg::*;

   localparam int unsigned ADDR_BITS = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int unsigned CNT_BITS = $clog2(MAX_HELD + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_POP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic stopped_ff, stopped_in;
   logic fatal_ff;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   logic [LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic [LEVEL_BITS-1:0] top_ff, top_in;
   logic pend_valid_ff, pend_valid_in;
   logic [LEVEL_BITS-1:0] pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // ram ports
   logic wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [LEVEL_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [LEVEL_BITS-1:0] entry;

   // helpers
   logic out_free;
   logic out_load;
   status_type out_status;
   logic [LEVEL_BITS-1:0] out_conflict;
   logic [CNT_BITS-1:0] out_count;
   logic out_last;
   logic [31:0] level_wide;
   logic [LEVEL_BITS-1:0] req_lvl;
   logic [31:0] conflict_wide;
   logic [31:0] count_wide;
   logic [CNT_BITS-1:0] cnt_dec;
   logic [ADDR_BITS-1:0] last_idx;
   logic at_end;
   logic viol;
   logic match;
   logic advance;
   logic [LEVEL_BITS-1:0] move_data;
   logic accept;

   lockord_ram #(
      .WIDTH(LEVEL_BITS),
      .DEPTH(MAX_HELD),
      .ADDR_BITS(ADDR_BITS)
   ) u_held_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(entry)
   );

   // width adaption of level, conflict and count fields
   assign level_wide = 32'(req_payload.level);
   assign req_lvl = level_wide[LEVEL_BITS-1:0];
   assign conflict_wide = 32'(out_conflict);
   assign count_wide = 32'(out_count);

   assign cnt_dec = count_ff - CNT_BITS'(1);
   assign last_idx = cnt_dec[ADDR_BITS-1:0];
   assign at_end = (idx_ff == last_idx);
   assign viol = (lvl_ff <= entry);
   assign match = (entry == lvl_ff);
   assign move_data = at_end ? entry : top_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_valid && req_ready;

   // sequencer: accept, table walks and response generation
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      stopped_in = stopped_ff;
      idx_in = idx_ff;
      lvl_in = lvl_ff;
      top_in = top_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[ADDR_BITS-1:0];
      wr_data = req_lvl;
      rd_addr = '0;
      advance = 1'b0;
      out_load = 1'b0;
      out_status = STATUS_OK;
      out_conflict = '0;
      out_count = count_ff;
      out_last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_payload.operation == OP_POP) ? last_idx : '0;
            if (accept) begin
               lvl_in = req_lvl;
               pend_valid_in = 1'b0;
               priority if (stopped_ff) begin
                  out_load = 1'b1;
                  out_status = STATUS_STOPPED;
               end else if (req_payload.operation == OP_CHECK) begin
                  if (count_ff == '0) begin
                     out_load = 1'b1;
                  end else begin
                     idx_in = '0;
                     state_in = ST_CHECK;
                  end
               end else if (req_payload.operation == OP_PUSH) begin
                  out_load = 1'b1;
                  if (count_ff < CNT_BITS'(MAX_HELD)) begin
                     wr_en = 1'b1;
                     count_in = count_ff + CNT_BITS'(1);
                     out_count = count_ff + CNT_BITS'(1);
                  end else begin
                     out_status = STATUS_FULL;
                  end
               end else if (req_payload.operation == OP_POP) begin
                  if (count_ff == '0) begin
                     out_load = 1'b1;
                     out_status = STATUS_NOT_FOUND;
                  end else begin
                     idx_in = last_idx;
                     state_in = ST_POP;
                  end
               end else begin
                  // unused operation code
                  out_load = 1'b1;
               end
            end
         end

         ST_CHECK: begin
            // one violation is held back so the final one can carry last
            advance = !(viol && (fatal_ff || pend_valid_ff)) || out_free;
            rd_addr = advance ? idx_ff + ADDR_BITS'(1) : idx_ff;
            if (advance) begin
               if (viol && fatal_ff) begin
                  out_load = 1'b1;
                  out_status = STATUS_VIOLATION;
                  out_conflict = entry;
                  stopped_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  if (viol) begin
                     pend_in = entry;
                     pend_valid_in = 1'b1;
                     if (pend_valid_ff) begin
                        out_load = 1'b1;
                        out_status = STATUS_VIOLATION;
                        out_conflict = pend_ff;
                        out_last = 1'b0;
                     end
                  end
                  if (at_end) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in = idx_ff + ADDR_BITS'(1);
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_status = pend_valid_ff ? STATUS_VIOLATION : STATUS_OK;
               out_conflict = pend_valid_ff ? pend_ff : '0;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_POP: begin
            // top entry is read first and kept for the swap
            if (at_end) begin
               top_in = entry;
            end
            advance = !(match || idx_ff == '0) || out_free;
            rd_addr = advance ? idx_ff - ADDR_BITS'(1) : idx_ff;
            if (advance) begin
               if (match) begin
                  wr_en = 1'b1;
                  wr_addr = idx_ff;
                  wr_data = move_data;
                  count_in = cnt_dec;
                  out_load = 1'b1;
                  out_count = cnt_dec;
                  state_in = ST_IDLE;
               end else if (idx_ff == '0) begin
                  out_load = 1'b1;
                  out_status = STATUS_NOT_FOUND;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - ADDR_BITS'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_data_in.status = out_status;
         rsp_data_in.conflict_level = conflict_wide[LEVEL_FIELD_BITS-1:0];
         rsp_data_in.count_held = count_wide[COUNT_FIELD_BITS-1:0];
         rsp_data_in.last = out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         stopped_ff <= 1'b0;
         fatal_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         stopped_ff <= stopped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fatal_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lvl_ff <= lvl_in;
      top_ff <= top_in;
      pend_ff <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // table count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_HELD))
      else $error("held count exceeds capacity");

   // stopped state is sticky
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped state cleared without reset");

   // a new response never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response overwritten");

   // count moves by at most one per cycle
   assert property (@(posedge clock) disable iff (reset)
      count_ff != count_in |-> (count_in == count_ff + CNT_BITS'(1))
         || (count_in == cnt_dec))
      else $error("held count jumped");
`endif

endmodule

`default_nettype wire

// ===== sim/lock_order_result_check.sv =====
`timescale 1ns / 1ps

// watches both channels of the lock order checker, predicts every response
// from its own copy of the held table and compares in arrival order
module lock_order_result_check (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire lockord_pkg::req_type req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire lockord_pkg::rsp_type rsp_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_wr_data,
   output int                        error_count,
   output int                        results_pending
);

   import lockord_pkg::*;

   localparam int HELD_LIMIT = 16;

   // shadow of the block state and its one register
   logic [7:0] held_levels [HELD_LIMIT];
   int         held_count = 0;
   bit         halted = 1'b0;
   bit         fatal_mode = 1'b0;
   int         mismatch_total = 0;
   rsp_type    results_due [$];

   // queue one expected response with the current held count
   function automatic void queue_result(status_type st, logic [7:0] conflict);
      rsp_type r;
      r.status = st;
      r.conflict_level = conflict;
      r.count_held = held_count[4:0];
      r.last = 1'b0;
      results_due.push_back(r);
   endfunction

   // expected responses of one request, updating the shadow table
   function automatic void predict_lock_results(req_type r);
      int      first_new;
      int      idx;
      bit      found;
      rsp_type tail;
      first_new = results_due.size();
      if (halted) begin
         queue_result(STATUS_STOPPED, 8'd0);
      end else begin
         case (r.operation)
            OP_CHECK: begin
               for (idx = 0; idx < held_count; idx++) begin
                  if (r.level <= held_levels[idx]) begin
                     queue_result(STATUS_VIOLATION, held_levels[idx]);
                     if (fatal_mode) begin
                        halted = 1'b1;
                        break;
                     end
                  end
               end
               if (results_due.size() == first_new) queue_result(STATUS_OK, 8'd0);
            end
            OP_PUSH: begin
               if (held_count < HELD_LIMIT) begin
                  held_levels[held_count] = r.level;
                  held_count++;
                  queue_result(STATUS_OK, 8'd0);
               end else begin
                  queue_result(STATUS_FULL, 8'd0);
               end
            end
            OP_POP: begin
               // search from the top, fill the hole with the top entry
               found = 1'b0;
               for (idx = held_count - 1; idx >= 0; idx--) begin
                  if (held_levels[idx] == r.level) begin
                     held_count--;
                     held_levels[idx] = held_levels[held_count];
                     found = 1'b1;
                     break;
                  end
               end
               queue_result(found ? STATUS_OK : STATUS_NOT_FOUND, 8'd0);
            end
            default: begin
               // unused opcode is answered but changes nothing
               queue_result(STATUS_OK, 8'd0);
            end
         endcase
      end
      tail = results_due[results_due.size() - 1];
      tail.last = 1'b1;
      results_due[results_due.size() - 1] = tail;
   endfunction

   // predict on request accept, then compare any response of the same edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         results_due.delete();
         held_count = 0;
         halted = 1'b0;
         fatal_mode = 1'b0;
      end else begin
         if (csr_wr_en) fatal_mode = csr_wr_data;
         if (req_valid && req_ready) predict_lock_results(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("unexpected response: status %0d conflict_level %0d count_held %0d",
                      rsp_payload.status, rsp_payload.conflict_level,
                      rsp_payload.count_held);
               mismatch_total++;
            end else begin
               want = results_due.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  mismatch_total++;
               end
               if (rsp_payload.conflict_level !== want.conflict_level) begin
                  $error("conflict_level: expected %0d, actual %0d",
                         want.conflict_level, rsp_payload.conflict_level);
                  mismatch_total++;
               end
               if (rsp_payload.count_held !== want.count_held) begin
                  $error("count_held: expected %0d, actual %0d",
                         want.count_held, rsp_payload.count_held);
                  mismatch_total++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_payload.last);
                  mismatch_total++;
               end
            end
         end
      end
      error_count <= mismatch_total;
      results_pending <= results_due.size();
   end

endmodule

// ===== sim/lock_order_checker_tb.sv =====
`timescale 1ns / 1ps

module lock_order_checker_tb;
   import lockord_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD = 400;
   localparam int STALL_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_wr_en;
   logic    csr_wr_data;
   int      error_count;
   int      results_pending;

   // idling control shared by sender and receiver
   bit jitter_on = 1'b0;
   bit calm = 1'b0;
   bit hold_requested = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lock_order_checker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lock_order_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   // alternate stretches with and without idling
   initial begin
      forever begin
         repeat ($urandom_range(16, 80)) @(posedge clock);
         jitter_on <= ($urandom_range(0, 3) != 0);
      end
   end

   // response side: random stall bursts plus one long hold to back up the block
   initial begin : receiver
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && hold_requested && !hold_done) begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && jitter_on && !calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // offer one request, with an optional idle burst first, until accepted
   task automatic send_request(input logic [1:0] op, input logic [7:0] lvl);
      req_type item;
      item.operation = op;
      item.level = lvl;
      if (jitter_on && !calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // levels mostly from a small pool so pops find their target
   function automatic logic [7:0] pick_level();
      logic [7:0] pool [8];
      pool = '{8'h00, 8'h01, 8'h10, 8'h55, 8'h7F, 8'h80, 8'hAA, 8'hFF};
      if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
      return 8'($urandom_range(0, 255));
   endfunction

   // random request; keep_clean keeps checks free of violations
   task automatic send_random(input bit keep_clean);
      int         roll;
      logic [1:0] op;
      logic [7:0] lvl;
      roll = $urandom_range(0, 99);
      lvl = pick_level();
      if (roll < 35) op = OP_PUSH;
      else if (roll < 65) op = OP_POP;
      else if (roll < 95) op = OP_CHECK;
      else op = OP_UNUSED;
      if (keep_clean && op == OP_PUSH && lvl == 8'hFF) lvl = 8'hFE;
      if (keep_clean && op == OP_CHECK) lvl = 8'hFF;
      send_request(op, lvl);
   endtask

   // stop offering, wait for every response, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fatal_mode(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] low_level;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests, fatal mode off
      write_fatal_mode(1'b0);
      send_request(OP_CHECK, 8'h00);
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_PUSH, 8'h10);
      send_request(OP_PUSH, 8'hFF);
      send_request(OP_PUSH, 8'h80);
      send_request(OP_PUSH, 8'h55);
      send_request(OP_PUSH, 8'hAA);
      send_request(OP_CHECK, 8'h00);
      send_request(OP_CHECK, 8'h81);
      send_request(OP_POP, 8'h55);
      send_request(OP_POP, 8'h07);
      send_request(OP_PUSH, 8'hFF);
      send_request(OP_POP, 8'hFF);
      // fill the table, overflow it, then a check that hits every entry
      repeat (12) begin
         low_level = 8'($urandom_range(0, 15));
         send_request(OP_PUSH, low_level);
      end
      send_request(OP_PUSH, 8'h33);
      send_request(OP_CHECK, 8'h00);
      wait_idle();

      // fatal mode on with violation-free checks
      write_fatal_mode(1'b1);
      send_request(OP_POP, 8'hFF);
      send_request(OP_CHECK, 8'hFF);
      repeat (20) send_random(1'b1);
      wait_idle();

      // main random run, fatal mode off, with one long response hold
      write_fatal_mode(1'b0);
      repeat (15) send_random(1'b0);
      hold_requested <= 1'b1;
      repeat (20) send_random(1'b0);
      wait_idle();

      // last part: no idling, fatal mode stops the block
      calm <= 1'b1;
      write_fatal_mode(1'b1);
      repeat (15) send_random(1'b0);
      send_request(OP_PUSH, 8'h20);
      send_request(OP_CHECK, 8'h00);
      repeat (5) send_random(1'b0);
      wait_idle();

      // clearing the mode does not leave the stopped state
      write_fatal_mode(1'b0);
      send_request(OP_PUSH, 8'h01);
      send_request(OP_POP, 8'h20);
      send_request(OP_CHECK, 8'hFF);
      send_request(OP_UNUSED, 8'h00);
      wait_idle();

      if (error_count == 0 && results_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
